FILE: sv/ssa_pkg.sv
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared constants and types for the sectioned slot allocator.
// ----------------------------------------------------------------------------
package ssa_pkg;

    localparam int SECTIONS      = 8;
    localparam int SEC_W         = $clog2(SECTIONS);
    localparam int MAX_SLOTS     = 1024;
    localparam int IDX_W         = $clog2(MAX_SLOTS);
    localparam int WORDS         = (MAX_SLOTS + 31) / 32;
    localparam int WORD_W        = $clog2(WORDS);
    localparam int MEM_DEPTH     = SECTIONS * WORDS;
    localparam int MEM_AW        = $clog2(MEM_DEPTH);
    localparam int SIZE_W        = 17;
    localparam int SLOTS_W       = IDX_W + 1;
    localparam int ADDR_W        = 19;
    localparam int OFF_W         = 16;
    localparam int CNT_W         = 11;
    localparam int PAGES         = 16;
    localparam int LEN_W         = SEC_W + 1;

    localparam logic [SIZE_W-1:0] SIZE_MIN   = 17'd64;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 17'd65536;
    localparam logic [SLOTS_W-1:0] SLOTS_RST = 11'd1024;

    typedef enum logic [1:0] {
        ST_UNUSED = 2'd0,
        ST_INUSE  = 2'd1,
        ST_HELD   = 2'd2
    } t_sec_status;

    typedef enum logic [1:0] {
        RS_OK       = 2'd0,
        RS_NO_SEC   = 2'd1,
        RS_BAD_ADDR = 2'd2,
        RS_NOT_USED = 2'd3
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CFG_DIV,
        S_START,
        S_SCAN,
        S_ALLOC_MUL,
        S_ALLOC_UPD,
        S_FREE_DIV,
        S_FREE_RD,
        S_FREE_CHK
    } t_state;

endpackage

FILE: sv/sectioned_slot_allocator.sv
// ----------------------------------------------------------------------------
// sectioned_slot_allocator
// Allocates and frees fixed-size slots in eight 64 KiB sections.
// ----------------------------------------------------------------------------
// Input channel i_valid / o_stall carries one item: i_cmd (0 allocate,
// 1 free) and i_address. Output channel o_valid / i_stall returns one
// result item per input item, held in an output register; a new item is
// taken while an earlier result still waits for the receiver.
// Items are worked one at a time. Slot bitmaps live in a 256 x 32 memory
// with a registered read; each bitmap word has a valid bit, so an
// unwritten or cleared word reads as zero.
// Allocate: picks a section, scans its bitmap words for a clear bit,
// then multiplies the slot index by the slot size to get the offset.
// Free: the serial offset / slot size divider, then a bitmap read.
// A slot size write (i_cfg_wr_en) runs the same serial divider to
// get slots per section; o_stall is high meanwhile and a further write
// restarts it. It takes effect only while every section is unused.
// Reset (i_rst_n low, synchronous) empties all sections and sets a slot
// size of 64. When the receiver stalls, the finishing item waits until
// the output register is free, and o_stall stays high.
// ----------------------------------------------------------------------------
module sectioned_slot_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [ssa_pkg::SIZE_W-1:0] i_cfg_wr_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_cmd,
    input  logic [ssa_pkg::ADDR_W-1:0] i_address,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [1:0]                 o_status,
    output logic [ssa_pkg::ADDR_W-1:0] o_slot_address,
    output logic                       o_commit_request,
    output logic [6:0]                 o_commit_first_page,
    output logic [4:0]                 o_commit_pages,
    output logic                       o_section_released,
    output logic [ssa_pkg::SEC_W-1:0]  o_released_section
);
    import ssa_pkg::*;

    logic [31:0] mem [MEM_DEPTH];

    t_state              r_state, n_state;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic [SLOTS_W-1:0]  r_slots, n_slots;
    logic [4:0]          r_div_cnt, n_div_cnt;
    logic [SIZE_W-1:0]   r_rem, n_rem;
    logic [SIZE_W-1:0]   r_dq, n_dq;
    logic                r_cmd, n_cmd;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [SEC_W-1:0]    r_sec, n_sec;
    logic                r_from_list, n_from_list;
    logic [WORD_W:0]     r_word, n_word;
    logic                r_pend, n_pend;
    logic [WORD_W-1:0]   r_pw, n_pw;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [31:0]         r_wdata, n_wdata;
    logic [OFF_W-1:0]    r_off, n_off;

    logic [CNT_W-1:0]    r_count [SECTIONS];
    logic [CNT_W-1:0]    n_count [SECTIONS];
    logic [PAGES-1:0]    r_mask [SECTIONS];
    logic [PAGES-1:0]    n_mask [SECTIONS];
    t_sec_status         r_stat [SECTIONS];
    t_sec_status         n_stat [SECTIONS];
    logic [SEC_W-1:0]    r_ready [SECTIONS];
    logic [SEC_W-1:0]    n_ready [SECTIONS];
    logic [LEN_W-1:0]    r_rlen, n_rlen;
    logic                r_held, n_held;
    logic [MEM_DEPTH-1:0] r_wvalid, n_wvalid;

    logic                r_ovalid, n_ovalid;
    logic [1:0]          r_ostatus, n_ostatus;
    logic [ADDR_W-1:0]   r_oaddr, n_oaddr;
    logic                r_ocreq, n_ocreq;
    logic [6:0]          r_ofirst, n_ofirst;
    logic [4:0]          r_opages, n_opages;
    logic                r_orel, n_orel;
    logic [SEC_W-1:0]    r_orelsec, n_orelsec;

    logic [31:0]         r_rdata;
    logic                r_rvalid;
    logic                rd_en;
    logic [MEM_AW-1:0]   rd_addr;
    logic                wr_en;
    logic [MEM_AW-1:0]   wr_addr;

    logic                out_free;
    logic [SIZE_W:0]     div_tmp;
    logic                div_ge;
    logic [31:0]         rdword;
    logic [31:0]         lim_mask;
    logic                zfound;
    logic [4:0]          zpos;
    logic [WORD_W:0]     nwords;
    logic [SIZE_W:0]     end_off;
    logic [3:0]          pg_first;
    logic [3:0]          pg_last;
    logic [PAGES-1:0]    pbits;
    logic [CNT_W-1:0]    cnt_new;
    logic                all_unused;
    logic                sel_found;
    logic [SEC_W-1:0]    sel_sec;
    logic                held_found;
    logic [SEC_W-1:0]    held_sec;
    logic                unused_found;
    logic [SEC_W-1:0]    unused_sec;
    logic                rfound;
    logic [LEN_W-1:0]    rpos;
    logic [26:0]         prod;

    assign o_stall             = (r_state != S_IDLE) || i_cfg_wr_en;
    assign o_valid             = r_ovalid;
    assign o_status            = r_ostatus;
    assign o_slot_address      = r_oaddr;
    assign o_commit_request    = r_ocreq;
    assign o_commit_first_page = r_ofirst;
    assign o_commit_pages      = r_opages;
    assign o_section_released  = r_orel;
    assign o_released_section  = r_orelsec;

    assign out_free = !r_ovalid || !i_stall;
    assign div_tmp  = {r_rem, r_dq[SIZE_W-1]};
    assign div_ge   = div_tmp >= {1'b0, r_size};
    assign rdword   = r_rvalid ? r_rdata : 32'd0;
    assign nwords   = (WORD_W+1)'((r_slots + SLOTS_W'(31)) >> 5);
    assign prod     = 27'(r_idx) * 27'(r_size);
    assign end_off  = {2'b00, r_off} + {1'b0, r_size} - 18'd1;
    assign pg_first = r_off[15:12];
    assign pg_last  = end_off[15:12];
    assign pbits    = (PAGES'(1) << pg_first) | (PAGES'(1) << pg_last);

    always_comb begin
        lim_mask = '0;
        for (int j = 0; j < 32; j++) begin
            lim_mask[j] = {1'b0, r_pw, 5'(j)} < r_slots;
        end
        zfound = 1'b0;
        zpos   = '0;
        for (int j = 31; j >= 0; j--) begin
            if (lim_mask[j] && !rdword[j]) begin
                zfound = 1'b1;
                zpos   = 5'(j);
            end
        end
    end

    always_comb begin
        all_unused   = 1'b1;
        held_found   = 1'b0;
        held_sec     = '0;
        unused_found = 1'b0;
        unused_sec   = '0;
        for (int s = SECTIONS - 1; s >= 0; s--) begin
            if (r_stat[s] != ST_UNUSED) all_unused = 1'b0;
            if (r_stat[s] == ST_HELD) begin
                held_found = 1'b1;
                held_sec   = SEC_W'(s);
            end
            if (r_stat[s] == ST_UNUSED) begin
                unused_found = 1'b1;
                unused_sec   = SEC_W'(s);
            end
        end
        sel_found = 1'b1;
        sel_sec   = r_ready[0];
        if (r_rlen == '0) begin
            if (r_held && held_found) begin
                sel_sec = held_sec;
            end else if (unused_found) begin
                sel_sec = unused_sec;
            end else begin
                sel_found = 1'b0;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_size      = r_size;
        n_slots     = r_slots;
        n_div_cnt   = r_div_cnt;
        n_rem       = r_rem;
        n_dq        = r_dq;
        n_cmd       = r_cmd;
        n_addr      = r_addr;
        n_sec       = r_sec;
        n_from_list = r_from_list;
        n_word      = r_word;
        n_pend      = r_pend;
        n_pw        = r_pw;
        n_idx       = r_idx;
        n_wdata     = r_wdata;
        n_off       = r_off;
        n_count     = r_count;
        n_mask      = r_mask;
        n_stat      = r_stat;
        n_ready     = r_ready;
        n_rlen      = r_rlen;
        n_held      = r_held;
        n_wvalid    = r_wvalid;
        n_ovalid    = r_ovalid;
        n_ostatus   = r_ostatus;
        n_oaddr     = r_oaddr;
        n_ocreq     = r_ocreq;
        n_ofirst    = r_ofirst;
        n_opages    = r_opages;
        n_orel      = r_orel;
        n_orelsec   = r_orelsec;
        rd_en       = 1'b0;
        rd_addr     = {r_sec, r_pw};
        wr_en       = 1'b0;
        wr_addr     = {r_sec, r_idx[IDX_W-1:5]};
        cnt_new     = '0;
        rfound      = 1'b0;
        rpos        = '0;

        if (r_ovalid && !i_stall) n_ovalid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid && !i_cfg_wr_en) begin
                    n_cmd   = i_cmd;
                    n_addr  = i_address;
                    n_state = S_START;
                end
            end
            S_CFG_DIV, S_FREE_DIV: begin
                n_rem     = div_ge ? SIZE_W'(div_tmp - {1'b0, r_size}) : SIZE_W'(div_tmp);
                n_dq      = {r_dq[SIZE_W-2:0], div_ge};
                n_div_cnt = r_div_cnt + 5'd1;
                if (r_div_cnt == 5'(SIZE_W - 1)) begin
                    if (r_state == S_CFG_DIV) begin
                        n_slots = n_dq[SLOTS_W-1:0];
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_FREE_RD;
                    end
                end
            end
            S_START: begin
                if (!r_cmd) begin
                    if (sel_found) begin
                        n_sec       = sel_sec;
                        n_from_list = (r_rlen != '0);
                        n_word      = '0;
                        n_pend      = 1'b0;
                        n_state     = S_SCAN;
                    end else if (out_free) begin
                        n_ovalid  = 1'b1;
                        n_ostatus = RS_NO_SEC;
                        n_oaddr   = '0;
                        n_ocreq   = 1'b0;
                        n_ofirst  = '0;
                        n_opages  = '0;
                        n_orel    = 1'b0;
                        n_orelsec = '0;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_sec = r_addr[ADDR_W-1:OFF_W];
                    if (r_stat[r_addr[ADDR_W-1:OFF_W]] == ST_INUSE) begin
                        n_rem     = '0;
                        n_dq      = {1'b0, r_addr[OFF_W-1:0]};
                        n_div_cnt = '0;
                        n_state   = S_FREE_DIV;
                    end else if (out_free) begin
                        n_ovalid  = 1'b1;
                        n_ostatus = RS_BAD_ADDR;
                        n_oaddr   = '0;
                        n_ocreq   = 1'b0;
                        n_ofirst  = '0;
                        n_opages  = '0;
                        n_orel    = 1'b0;
                        n_orelsec = '0;
                        n_state   = S_IDLE;
                    end
                end
            end
            S_SCAN: begin
                if (r_pend && zfound) begin
                    n_idx   = {r_pw, zpos};
                    n_wdata = rdword | (32'd1 << zpos);
                    n_state = S_ALLOC_MUL;
                end else if (r_word < nwords) begin
                    rd_en   = 1'b1;
                    rd_addr = {r_sec, r_word[WORD_W-1:0]};
                    n_pw    = r_word[WORD_W-1:0];
                    n_word  = r_word + 1'b1;
                    n_pend  = 1'b1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = RS_NO_SEC;
                    n_oaddr   = '0;
                    n_ocreq   = 1'b0;
                    n_ofirst  = '0;
                    n_opages  = '0;
                    n_orel    = 1'b0;
                    n_orelsec = '0;
                    n_state   = S_IDLE;
                end
            end
            S_ALLOC_MUL: begin
                n_off   = prod[OFF_W-1:0];
                n_state = S_ALLOC_UPD;
            end
            S_ALLOC_UPD: begin
                if (out_free) begin
                    if (!r_from_list) begin
                        if (r_stat[r_sec] == ST_HELD) n_held = 1'b0;
                        n_stat[r_sec] = ST_INUSE;
                        for (int i = 0; i < SECTIONS; i++) begin
                            if (LEN_W'(i) < r_rlen && r_ready[i] == r_sec) rfound = 1'b1;
                        end
                        if (!rfound && r_rlen < LEN_W'(SECTIONS)) begin
                            for (int i = 1; i < SECTIONS; i++) begin
                                n_ready[i] = r_ready[i-1];
                            end
                            n_ready[0] = r_sec;
                            n_rlen     = r_rlen + 1'b1;
                        end
                    end
                    wr_en              = 1'b1;
                    n_wvalid[wr_addr]  = 1'b1;
                    cnt_new            = r_count[r_sec] + 1'b1;
                    n_count[r_sec]     = cnt_new;
                    n_ocreq            = 1'b0;
                    n_ofirst           = '0;
                    n_opages           = '0;
                    if ((r_mask[r_sec] & pbits) != pbits) begin
                        n_ocreq       = 1'b1;
                        n_ofirst      = {r_sec, pg_first};
                        n_opages      = 5'(pg_last - pg_first) + 5'd1;
                        n_mask[r_sec] = r_mask[r_sec] | pbits;
                    end
                    if ({1'b0, cnt_new} >= {1'b0, r_slots}) begin
                        rfound = 1'b0;
                        for (int i = SECTIONS - 1; i >= 0; i--) begin
                            if (LEN_W'(i) < n_rlen && n_ready[i] == r_sec) begin
                                rfound = 1'b1;
                                rpos   = LEN_W'(i);
                            end
                        end
                        if (rfound) begin
                            for (int i = 0; i < SECTIONS - 1; i++) begin
                                if (LEN_W'(i) >= rpos) n_ready[i] = n_ready[i+1];
                            end
                            n_rlen = n_rlen - 1'b1;
                        end
                    end
                    n_ovalid  = 1'b1;
                    n_ostatus = RS_OK;
                    n_oaddr   = {r_sec, r_off};
                    n_orel    = 1'b0;
                    n_orelsec = '0;
                    n_state   = S_IDLE;
                end
            end
            S_FREE_RD: begin
                if ({6'd0, r_slots} <= r_dq) begin
                    if (out_free) begin
                        n_ovalid  = 1'b1;
                        n_ostatus = RS_NOT_USED;
                        n_oaddr   = '0;
                        n_ocreq   = 1'b0;
                        n_ofirst  = '0;
                        n_opages  = '0;
                        n_orel    = 1'b0;
                        n_orelsec = '0;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_idx   = r_dq[IDX_W-1:0];
                    rd_en   = 1'b1;
                    rd_addr = {r_sec, r_dq[IDX_W-1:5]};
                    n_state = S_FREE_CHK;
                end
            end
            S_FREE_CHK: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_oaddr   = '0;
                    n_ocreq   = 1'b0;
                    n_ofirst  = '0;
                    n_opages  = '0;
                    n_orel    = 1'b0;
                    n_orelsec = '0;
                    n_state   = S_IDLE;
                    if (!rdword[r_idx[4:0]]) begin
                        n_ostatus = RS_NOT_USED;
                    end else begin
                        n_ostatus         = RS_OK;
                        n_wdata           = rdword & ~(32'd1 << r_idx[4:0]);
                        wr_en             = 1'b1;
                        n_wvalid[wr_addr] = 1'b1;
                        cnt_new           = r_count[r_sec];
                        if (cnt_new != '0) cnt_new = cnt_new - 1'b1;
                        n_count[r_sec] = cnt_new;
                        for (int i = SECTIONS - 1; i >= 0; i--) begin
                            if (LEN_W'(i) < r_rlen && r_ready[i] == r_sec) begin
                                rfound = 1'b1;
                                rpos   = LEN_W'(i);
                            end
                        end
                        if ({1'b0, cnt_new} == r_slots - 1'b1) begin
                            if (!rfound && r_rlen < LEN_W'(SECTIONS)) begin
                                n_ready[r_rlen[SEC_W-1:0]] = r_sec;
                                n_rlen = r_rlen + 1'b1;
                            end
                        end else if (cnt_new == '0) begin
                            if (rfound) begin
                                for (int i = 0; i < SECTIONS - 1; i++) begin
                                    if (LEN_W'(i) >= rpos) n_ready[i] = r_ready[i+1];
                                end
                                n_rlen = r_rlen - 1'b1;
                            end
                            if (r_held) begin
                                for (int w = 0; w < WORDS; w++) begin
                                    n_wvalid[{r_sec, WORD_W'(w)}] = 1'b0;
                                end
                                n_count[r_sec] = '0;
                                n_mask[r_sec]  = '0;
                                n_stat[r_sec]  = ST_UNUSED;
                                n_orel         = 1'b1;
                                n_orelsec      = r_sec;
                            end else begin
                                n_stat[r_sec] = ST_HELD;
                                n_held        = 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // slot size write, restarts a running slot count
        if (i_cfg_wr_en && all_unused &&
            (r_state == S_IDLE || r_state == S_CFG_DIV)) begin
            if (i_cfg_wr_data < SIZE_MIN) begin
                n_size = SIZE_MIN;
            end else if (i_cfg_wr_data > SIZE_MAX) begin
                n_size = SIZE_MAX;
            end else begin
                n_size = i_cfg_wr_data;
            end
            n_rem     = '0;
            n_dq      = SIZE_MAX;
            n_div_cnt = '0;
            n_state   = S_CFG_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= n_wdata;
        if (rd_en) begin
            r_rdata  <= mem[rd_addr];
            r_rvalid <= r_wvalid[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_size   <= SIZE_MIN;
            r_slots  <= SLOTS_RST;
            r_rlen   <= '0;
            r_held   <= 1'b0;
            r_wvalid <= '0;
            r_ovalid <= 1'b0;
            for (int s = 0; s < SECTIONS; s++) begin
                r_count[s] <= '0;
                r_mask[s]  <= '0;
                r_stat[s]  <= ST_UNUSED;
            end
        end else begin
            r_state  <= n_state;
            r_size   <= n_size;
            r_slots  <= n_slots;
            r_rlen   <= n_rlen;
            r_held   <= n_held;
            r_wvalid <= n_wvalid;
            r_ovalid <= n_ovalid;
            r_count  <= n_count;
            r_mask   <= n_mask;
            r_stat   <= n_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div_cnt   <= n_div_cnt;
        r_rem       <= n_rem;
        r_dq        <= n_dq;
        r_cmd       <= n_cmd;
        r_addr      <= n_addr;
        r_sec       <= n_sec;
        r_from_list <= n_from_list;
        r_word      <= n_word;
        r_pend      <= n_pend;
        r_pw        <= n_pw;
        r_idx       <= n_idx;
        r_wdata     <= n_wdata;
        r_off       <= n_off;
        r_ready     <= n_ready;
        r_ostatus   <= n_ostatus;
        r_oaddr     <= n_oaddr;
        r_ocreq     <= n_ocreq;
        r_ofirst    <= n_ofirst;
        r_opages    <= n_opages;
        r_orel      <= n_orel;
        r_orelsec   <= n_orelsec;
    end

endmodule
